FILE: rtl/firewall_rule_table_classifier_macros.svh
// Assertion macros for the rule table classifier checker
`ifndef FIREWALL_RULE_TABLE_CLASSIFIER_MACROS_SVH
`define FIREWALL_RULE_TABLE_CLASSIFIER_MACROS_SVH
// property that holds in the cycle after the trigger
`define FRTC_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);
// property that holds in the same cycle as the trigger
`define FRTC_SAME(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error(msg);
`endif

FILE: rtl/frtc_pkg.sv
// Shared types and constants for the rule table classifier
package frtc_pkg;
	localparam int RULES = 16;
	localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CNT_W = $clog2(RULES + 1);
	localparam int QDEPTH = 2;

	localparam logic [1:0] FN_CLASSIFY = 2'd0;
	localparam logic [1:0] FN_ADD = 2'd1;
	localparam logic [1:0] FN_DELETE = 2'd2;
	localparam logic [1:0] FN_FLUSH = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_MISS = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic direction;
		logic [7:0] proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0] rule_action;
	} req_t;

	typedef struct packed {
		logic matched;
		logic [7:0] verdict;
		logic [31:0] hit_count;
		logic [3:0] slot;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic direction;
		logic [7:0] proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0] action;
	} rule_t;

	// front decision handed to the back part
	typedef struct packed {
		logic [1:0] func;
		logic found;
		logic [IDX_W-1:0] idx;
		rule_t rule;
	} cmd_t;
endpackage

FILE: rtl/frtc_if.sv
// Valid/ready channel interfaces for requests and responses
interface frtc_req_if;
	import frtc_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface frtc_rsp_if;
	import frtc_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/frtc_front.sv
// Front part: takes a request and finds the matching rule index
module frtc_front (
	frtc_req_if.sink req,
	input logic [frtc_pkg::RULES-1:0] rule_vld,
	input frtc_pkg::rule_t rules [frtc_pkg::RULES],
	input logic busy,
	output logic cmd_valid,
	output frtc_pkg::cmd_t cmd
);
	import frtc_pkg::*;

	logic [RULES-1:0] hit;
	logic found;
	logic [IDX_W-1:0] idx;

	// table updates at the transfer edge; input stalls only on a full response queue
	assign req.ready = !busy;
	assign cmd_valid = req.valid && !busy;

	always_comb begin
		for (int i = 0; i < RULES; i++) begin
			if (req.data.func == FN_CLASSIFY) begin
				hit[i] = rule_vld[i] && rules[i].direction == req.data.direction &&
					(rules[i].proto == '0 || rules[i].proto == req.data.proto) &&
					(rules[i].src_ip == '0 || rules[i].src_ip == req.data.src_ip) &&
					(rules[i].dst_ip == '0 || rules[i].dst_ip == req.data.dst_ip) &&
					(rules[i].src_port == '0 || rules[i].src_port == req.data.src_port) &&
					(rules[i].dst_port == '0 || rules[i].dst_port == req.data.dst_port);
			end else begin
				hit[i] = rule_vld[i] && rules[i].direction == req.data.direction &&
					rules[i].proto == req.data.proto &&
					rules[i].src_ip == req.data.src_ip &&
					rules[i].dst_ip == req.data.dst_ip &&
					rules[i].src_port == req.data.src_port &&
					rules[i].dst_port == req.data.dst_port;
			end
		end
		found = 1'b0;
		idx = '0;
		for (int i = RULES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		cmd.func = req.data.func;
		cmd.found = found;
		cmd.idx = idx;
		cmd.rule.direction = req.data.direction;
		cmd.rule.proto = req.data.proto;
		cmd.rule.src_ip = req.data.src_ip;
		cmd.rule.dst_ip = req.data.dst_ip;
		cmd.rule.src_port = req.data.src_port;
		cmd.rule.dst_port = req.data.dst_port;
		cmd.rule.action = req.data.rule_action;
	end
endmodule

FILE: rtl/frtc_back.sv
// Back part: rule table update and response queue
module frtc_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input frtc_pkg::cmd_t cmd,
	output logic [frtc_pkg::RULES-1:0] rule_vld,
	output frtc_pkg::rule_t rules [frtc_pkg::RULES],
	output logic busy,
	frtc_rsp_if.source rsp
);
	import frtc_pkg::*;

	rule_t rule_q [RULES];
	logic [31:0] hits_q [RULES];
	logic [CNT_W-1:0] count_q;
	rsp_t rsp_q [QDEPTH];
	logic [1:0] qcnt_q;

	rsp_t r;
	logic [31:0] hnext;
	logic full;

	assign full = count_q == CNT_W'(RULES);
	assign hnext = hits_q[cmd.idx] + 32'd1;
	assign busy = qcnt_q == 2'(QDEPTH);
	assign rules = rule_q;
	assign rsp.valid = qcnt_q != '0;
	assign rsp.data = rsp_q[0];

	always_comb begin
		for (int i = 0; i < RULES; i++) rule_vld[i] = CNT_W'(i) < count_q;
	end

	always_comb begin
		r = '0;
		case (cmd.func)
			FN_CLASSIFY: begin
				r.status = cmd.found ? ST_DONE : ST_MISS;
				if (cmd.found) begin
					r.matched = 1'b1;
					r.verdict = rule_q[cmd.idx].action;
					r.hit_count = hnext;
					r.slot = 4'(cmd.idx);
				end
			end
			FN_ADD: begin
				if (cmd.found) begin
					r.matched = 1'b1;
					r.verdict = rule_q[cmd.idx].action;
					r.hit_count = hits_q[cmd.idx];
					r.slot = 4'(cmd.idx);
					r.status = ST_DUP;
				end else if (full) begin
					r.status = ST_FULL;
				end else begin
					r.slot = 4'(count_q);
				end
			end
			FN_DELETE: begin
				r.status = cmd.found ? ST_DONE : ST_MISS;
				if (cmd.found) begin
					r.matched = 1'b1;
					r.verdict = rule_q[cmd.idx].action;
					r.hit_count = hits_q[cmd.idx];
					r.slot = 4'(cmd.idx);
				end
			end
			default: r.status = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd_valid) begin
			case (cmd.func)
				FN_ADD: if (!cmd.found && !full) count_q <= count_q + 1'b1;
				FN_DELETE: if (cmd.found) count_q <= count_q - 1'b1;
				FN_FLUSH: count_q <= '0;
				default: count_q <= count_q;
			endcase
		end
	end

	// table payload, shift-down on delete keeps order
	always_ff @(posedge clk) begin
		if (cmd_valid) begin
			case (cmd.func)
				FN_CLASSIFY: if (cmd.found) hits_q[cmd.idx] <= hnext;
				FN_ADD: begin
					if (!cmd.found && !full) begin
						rule_q[IDX_W'(count_q)] <= cmd.rule;
						hits_q[IDX_W'(count_q)] <= '0;
					end
				end
				FN_DELETE: begin
					if (cmd.found) begin
						for (int i = 0; i < RULES - 1; i++) begin
							if (IDX_W'(i) >= cmd.idx) begin
								rule_q[i] <= rule_q[i+1];
								hits_q[i] <= hits_q[i+1];
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	logic push, pop;
	assign push = cmd_valid;
	assign pop = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
		end else begin
			qcnt_q <= qcnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && (qcnt_q == 2'd0 || (qcnt_q == 2'd1 && pop))) rsp_q[0] <= r;
		else if (pop) rsp_q[0] <= rsp_q[1];
		if (push && qcnt_q == 2'd1 && !pop) rsp_q[1] <= r;
	end
endmodule

FILE: rtl/firewall_rule_table_classifier.sv
// A request is looked up and applied in its accept cycle; its response is
// registered into the response queue. One request per cycle is taken while the
// two-entry response queue has room; the queue stalls input when full.
// The rule lookup compares all rules in parallel against table registers.
// Reset empties the table and the response queue.
module firewall_rule_table_classifier (
	input logic clk,
	input logic arst_n,
	frtc_req_if.sink req,
	frtc_rsp_if.source rsp
);
	import frtc_pkg::*;

	logic [RULES-1:0] rule_vld;
	rule_t rules [RULES];
	logic busy;
	logic cmd_valid;
	cmd_t cmd;

	frtc_front u_front (
		.req(req), .rule_vld(rule_vld), .rules(rules),
		.busy(busy), .cmd_valid(cmd_valid), .cmd(cmd)
	);

	frtc_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.rule_vld(rule_vld), .rules(rules), .busy(busy), .rsp(rsp)
	);
endmodule

FILE: rtl/frtc_checker.sv
// Port-level checker for the rule table classifier
`include "firewall_rule_table_classifier_macros.svh"
module frtc_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] rsp_status,
	input logic rsp_matched,
	input logic [7:0] rsp_verdict
);
	import frtc_pkg::*;

	`FRTC_NEXT(a_resp_follows, req_valid && req_ready, rsp_valid, "no response after transfer")
	`FRTC_SAME(a_miss_clean, rsp_valid && rsp_status == ST_MISS, !rsp_matched && rsp_verdict == 8'd0, "miss carries data")
	`FRTC_SAME(a_full_clean, rsp_valid && rsp_status == ST_FULL, !rsp_matched, "full marked matched")
	`FRTC_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
endmodule

bind firewall_rule_table_classifier frtc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status),
	.rsp_matched(rsp.data.matched), .rsp_verdict(rsp.data.verdict)
);

FILE: tb/firewall_rule_table_classifier_tb_pkg.sv
// Scoreboard class for the rule table classifier testbench
package frtc_tb_pkg;
	import frtc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	class rule_table_scoreboard;
		rule_t rules[RULES];
		logic [31:0] hits[RULES];
		int unsigned rule_count;
		rsp_t verdicts_due[$];
		int unsigned errors;
		int unsigned n_checked;
		int unsigned n_hits, n_dups, n_full, n_deletes;

		function void clear();
			rule_count = 0;
			verdicts_due.delete();
		endfunction

		function bit same_key(int unsigned i, req_t r);
			return rules[i].direction == r.direction && rules[i].proto == r.proto &&
				rules[i].src_ip == r.src_ip && rules[i].dst_ip == r.dst_ip &&
				rules[i].src_port == r.src_port && rules[i].dst_port == r.dst_port;
		endfunction

		function bit wild_ok(logic [31:0] rv, logic [31:0] pv);
			return rv == 0 || rv == pv;
		endfunction

		// works out the response of one accepted request and updates the table
		function void note_request(req_t r);
			rsp_t e;
			bit hit;
			e = '0;
			hit = 0;
			case (r.func)
				FN_CLASSIFY: begin
					e.status = ST_MISS;
					for (int unsigned i = 0; i < rule_count && !hit; i++) begin
						if (rules[i].direction == r.direction &&
							wild_ok(rules[i].proto, r.proto) &&
							wild_ok(rules[i].src_ip, r.src_ip) &&
							wild_ok(rules[i].dst_ip, r.dst_ip) &&
							wild_ok(rules[i].src_port, r.src_port) &&
							wild_ok(rules[i].dst_port, r.dst_port)) begin
							hit = 1;
							hits[i] = hits[i] + 1;
							e.matched = 1;
							e.verdict = rules[i].action;
							e.hit_count = hits[i];
							e.slot = i[3:0];
							e.status = ST_DONE;
							n_hits++;
						end
					end
				end
				FN_ADD: begin
					for (int unsigned i = 0; i < rule_count && !hit; i++) begin
						if (same_key(i, r)) begin
							hit = 1;
							e.matched = 1;
							e.verdict = rules[i].action;
							e.hit_count = hits[i];
							e.slot = i[3:0];
							e.status = ST_DUP;
							n_dups++;
						end
					end
					if (!hit) begin
						if (rule_count >= RULES) begin
							e.status = ST_FULL;
							n_full++;
						end else begin
							rules[rule_count] = '{r.direction, r.proto, r.src_ip, r.dst_ip,
								r.src_port, r.dst_port, r.rule_action};
							hits[rule_count] = 0;
							e.slot = rule_count[3:0];
							rule_count++;
						end
					end
				end
				FN_DELETE: begin
					e.status = ST_MISS;
					for (int unsigned i = 0; i < rule_count && !hit; i++) begin
						if (same_key(i, r)) begin
							hit = 1;
							e.matched = 1;
							e.verdict = rules[i].action;
							e.hit_count = hits[i];
							e.slot = i[3:0];
							e.status = ST_DONE;
							for (int unsigned j = i; j + 1 < rule_count; j++) begin
								rules[j] = rules[j + 1];
								hits[j] = hits[j + 1];
							end
							rule_count--;
							n_deletes++;
						end
					end
				end
				default: rule_count = 0;
			endcase
			verdicts_due.push_back(e);
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (verdicts_due.size() == 0) begin
				$error("unexpected response %h", a);
				errors++;
				return;
			end
			e = verdicts_due.pop_front();
			n_checked++;
			if (a.matched !== e.matched) begin
				$error("matched: expected %0d, got %0d", e.matched, a.matched);
				errors++;
			end
			if (a.verdict !== e.verdict) begin
				$error("verdict: expected %0d, got %0d", e.verdict, a.verdict);
				errors++;
			end
			if (a.hit_count !== e.hit_count) begin
				$error("hit_count: expected %0d, got %0d", e.hit_count, a.hit_count);
				errors++;
			end
			if (a.slot !== e.slot) begin
				$error("slot: expected %0d, got %0d", e.slot, a.slot);
				errors++;
			end
			if (a.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, a.status);
				errors++;
			end
		endfunction
	endclass
endpackage

FILE: tb/testbench.sv
// Top level testbench for the rule table classifier
module testbench;
	import frtc_pkg::*;
	import frtc_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	frtc_req_if req();
	frtc_rsp_if rsp();

	rule_table_scoreboard table_model = new();
	int unsigned send_idle_pct = 13;
	int unsigned recv_idle_pct = 76;
	bit recv_hold = 0;
	int unsigned cycles = 0;
	req_t keys[$];

	firewall_rule_table_classifier dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #6 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		table_model.clear();
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// note transfers on both channels
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			table_model.note_request(req.data);
		if (arst_n && rsp.valid && rsp.ready)
			table_model.check_response(rsp.data);
	end

	always @(posedge clk) begin
		if (!arst_n || recv_hold)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// valid stays up after a transfer; the next send may take it down, drain does
	task automatic send(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (table_model.verdicts_due.size() != 0) @(posedge clk);
	endtask

	function automatic req_t make_req(logic [1:0] f, req_t k, logic [7:0] act);
		req_t r;
		r = k;
		r.func = f;
		r.rule_action = act;
		return r;
	endfunction

	// mostly small values so wildcards and key collisions happen often
	function automatic logic [31:0] pick(int w);
		logic [63:0] mask;
		mask = (64'd1 << w) - 64'd1;
		case ($urandom_range(3))
			0: return '0;
			1: return $urandom_range(3);
			2: return 32'($urandom() & mask);
			default: return 32'(mask - 64'($urandom_range(1)));
		endcase
	endfunction

	function automatic req_t rand_key();
		req_t r;
		r = '0;
		r.direction = 1'($urandom_range(1));
		r.proto = 8'(pick(8));
		r.src_ip = pick(32);
		r.dst_ip = pick(32);
		r.src_port = 16'(pick(16));
		r.dst_port = 16'(pick(16));
		r.rule_action = 8'($urandom());
		return r;
	endfunction

	task automatic random_item();
		req_t r;
		int unsigned k;
		k = $urandom_range(99);
		if (k < 30) begin
			r = make_req(FN_ADD, rand_key(), 8'($urandom()));
			keys.push_back(r);
			if (keys.size() > 40) void'(keys.pop_front());
		end else if (k < 70) begin
			// classify a packet usually derived from a known rule, zero proto and IP fields filled in
			r = keys.size() ? keys[$urandom_range(keys.size() - 1)] : rand_key();
			if (r.proto == 0) r.proto = 8'($urandom());
			if (r.src_ip == 0) r.src_ip = $urandom();
			if (r.dst_ip == 0) r.dst_ip = $urandom();
			if ($urandom_range(4) == 0) r = rand_key();
			r.func = FN_CLASSIFY;
			r.rule_action = 8'($urandom());
		end else if (k < 80) begin
			r = keys.size() ? keys[$urandom_range(keys.size() - 1)] : rand_key();
			r.func = FN_ADD;
			r.rule_action = 8'($urandom());
		end else if (k < 97) begin
			r = keys.size() ? keys[$urandom_range(keys.size() - 1)] : rand_key();
			if ($urandom_range(3) == 0) r = rand_key();
			r.func = FN_DELETE;
		end else begin
			r = rand_key();
			r.func = FN_FLUSH;
		end
		send(r);
	endtask

	initial begin
		req_t k;
		req_t ones;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, miss, add, dup, full, delete, flush
		ones = '1;
		send(make_req(FN_CLASSIFY, ones, 8'hff));
		send(make_req(FN_ADD, ones, 8'hff));
		send(make_req(FN_ADD, ones, 8'h01));
		send(make_req(FN_CLASSIFY, ones, 8'h00));
		k = '0;
		send(make_req(FN_ADD, k, 8'h00));
		k.direction = 1'b1;
		send(make_req(FN_ADD, k, 8'h01));
		send(make_req(FN_CLASSIFY, ones, 8'h00));
		for (int i = 0; i < 15; i++) begin
			k = rand_key();
			k.src_port = 16'(i + 100);
			send(make_req(FN_ADD, k, 8'(i)));
		end
		send(make_req(FN_DELETE, ones, 8'h00));
		send(make_req(FN_DELETE, ones, 8'h00));
		send(make_req(FN_FLUSH, '0, 8'h00));
		send(make_req(FN_CLASSIFY, ones, 8'h00));

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 76 : 0;
			recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 13 : 0;
			if (phase == 2) begin
				// long receiver hold-off while the sender keeps offering
				fork
					begin
						recv_hold = 1;
						repeat (60) @(posedge clk);
						recv_hold = 0;
					end
					repeat (20) random_item();
				join
			end
			repeat (290) random_item();
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Checked %0d responses: %0d hits, %0d duplicates, %0d full, %0d deletes",
			table_model.n_checked, table_model.n_hits, table_model.n_dups,
			table_model.n_full, table_model.n_deletes);
		if (table_model.errors == 0 && table_model.verdicts_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
